FILE: hw/rtl/wudmr_pkg.sv
// Shared constants and types for the windowed up/down move ratio block.
`timescale 1ns / 1ps
`default_nettype none
package wudmr_pkg;
  localparam int unsigned HistoryDepth = 1024;
  localparam int unsigned MaxWindows   = 4;
  localparam int unsigned LenRegs      = 4;
  localparam logic [31:0] LenReset0    = 32'd60;
  localparam logic [31:0] LenReset1    = 32'd300;
  localparam logic [31:0] LenReset2    = 32'd900;
  localparam logic [31:0] LenReset3    = 32'd3600;
  localparam logic [31:0] QMax         = 32'hFFFF_FFFF;

  // Register addresses (word index).
  localparam logic [2:0] RegLen0  = 3'd0;
  localparam logic [2:0] RegLen1  = 3'd1;
  localparam logic [2:0] RegLen2  = 3'd2;
  localparam logic [2:0] RegLen3  = 3'd3;
  localparam logic [2:0] RegCount = 3'd4;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WRITE = 7'b0000010,
    ST_FIRST = 7'b0000100,
    ST_WALK  = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_HOLD  = 7'b1000000
  } state_e;
endpackage
`default_nettype wire

FILE: hw/rtl/windowed_up_down_move_ratio_top.sv
// Top level of the windowed up/down move ratio block.
//
// Each accepted quote is written into a history ring held in two synchronous
// memories. The oldest held entry is then read to decide whether the history
// spans more than the longest active window. When it does, the ring is walked
// back from the newest entry, one entry per cycle, summing rises and falls for
// every active window. Each ratio then goes through a restoring divider that
// produces one quotient bit per cycle over 80 steps. Each active window takes
// two divisions, the up ratio and then the down ratio, and then hands its word
// to the output register, waiting while that register holds a stalled word.
// One quote is handled at a time, so the input is stalled until the last word
// of a quote has been handed over and the sequencer has returned to idle.
// Results leave through an output register, one word per window.
`timescale 1ns / 1ps
`default_nettype none
module windowed_up_down_move_ratio_top #(
  parameter int unsigned HISTORY_DEPTH = wudmr_pkg::HistoryDepth,
  parameter int unsigned MAX_WINDOWS   = wudmr_pkg::MaxWindows
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] quote_time_i,
  input  wire logic [31:0] quote_price_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       window_index_o,
  output logic [31:0]      up_ratio_o,
  output logic [31:0]      down_ratio_o,
  output logic             up_div_zero_o,
  output logic             down_div_zero_o,
  output logic             history_ready_o,
  output logic             last_window_o
);
  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned NumWin = (MAX_WINDOWS < wudmr_pkg::LenRegs) ?
                                   MAX_WINDOWS : wudmr_pkg::LenRegs;
  localparam logic [FW-1:0] DepthF = FW'(HISTORY_DEPTH);
  localparam logic [2:0] NumWin3 = 3'(NumWin);

  // Configuration registers.
  logic [31:0] len_q [4];
  logic [2:0]  count_q;
  logic [2:0]  reg_idx;
  logic        cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q[0] <= wudmr_pkg::LenReset0;
      len_q[1] <= wudmr_pkg::LenReset1;
      len_q[2] <= wudmr_pkg::LenReset2;
      len_q[3] <= wudmr_pkg::LenReset3;
      count_q  <= 3'd1;
    end else if (cfg_we) begin
      if (reg_idx == wudmr_pkg::RegCount) begin
        count_q <= pwdata[2:0];
      end else if (reg_idx < wudmr_pkg::RegCount && reg_idx < NumWin3) begin
        len_q[reg_idx[1:0]] <= pwdata;
      end
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    if (reg_idx == wudmr_pkg::RegCount) begin
      prdata = {29'd0, count_q};
    end else if (reg_idx < wudmr_pkg::RegCount) begin
      prdata = len_q[reg_idx[1:0]];
    end
  end

  // Active window count and longest window.
  logic [2:0]  cnt;
  logic [31:0] maxw;
  always_comb begin
    cnt = count_q;
    if (cnt == 3'd0) cnt = 3'd1;
    if (cnt > NumWin3) cnt = NumWin3;
    maxw = '0;
    for (int w = 0; w < 4; w++) begin
      if (3'(w) < cnt && len_q[w] > maxw) maxw = len_q[w];
    end
  end

  // Sequencer state.
  wudmr_pkg::state_e state_q;
  logic [31:0]   quote_time_q, quote_price_q;
  logic [AW-1:0] head_q;
  logic [FW-1:0] fill_q;
  logic [FW-1:0] back_q;      // entry index being read (steps back from newest)
  logic [31:0]   prev_price_q; // price of the newer entry of the pair
  logic [31:0]   ageq_q;       // age of the newer entry of the pair
  logic          have_prev_q;
  logic          ready_q;
  logic [63:0]   rise_q [4];
  logic [63:0]   fall_q [4];
  logic [1:0]    win_q;
  logic          dir_q;       // 0: up ratio, 1: down ratio
  logic [6:0]    step_q;
  logic [95:0]   rem_q;
  logic [79:0]   quo_q;
  logic [31:0]   up_q;
  logic          up_dz_q;
  logic [31:0]   dn_q;
  logic          dn_dz_q;

  // Output register.
  logic        ov_q;
  logic [1:0]  o_win_q;
  logic [31:0] o_up_q, o_dn_q;
  logic        o_udz_q, o_ddz_q, o_rdy_q, o_last_q;

  // History ring memories.
  logic [31:0] mem_time  [HISTORY_DEPTH];
  logic [31:0] mem_price [HISTORY_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   rd_time, rd_price;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_time[mem_waddr]  <= quote_time_q;
      mem_price[mem_waddr] <= quote_price_q;
    end
    rd_time  <= mem_time[mem_raddr];
    rd_price <= mem_price[mem_raddr];
  end

  assign in_stall_o      = (state_q != wudmr_pkg::ST_IDLE);
  assign out_valid_o     = ov_q;
  assign window_index_o  = o_win_q;
  assign up_ratio_o      = o_up_q;
  assign down_ratio_o    = o_dn_q;
  assign up_div_zero_o   = o_udz_q;
  assign down_div_zero_o = o_ddz_q;
  assign history_ready_o = o_rdy_q;
  assign last_window_o   = o_last_q;

  logic [FW-1:0] fill_new;
  assign fill_new = (fill_q < DepthF) ? fill_q + 1'b1 : fill_q;

  // Slot back from the newest entry (head already advanced).
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [FW-1:0] back);
    logic [FW:0] s;
    begin
      s = (FW+1)'(head) + (FW+1)'(HISTORY_DEPTH - 1) - (FW+1)'(back);
      if (s >= (FW+1)'(HISTORY_DEPTH)) s = s - (FW+1)'(HISTORY_DEPTH);
      slot_of = AW'(s);
    end
  endfunction

  // Age of the entry whose data has just arrived.
  logic [31:0] age;
  assign age = quote_time_q - rd_time;

  // Current numerator and denominator of the division.
  logic [63:0] num, den;
  always_comb begin
    num = dir_q ? fall_q[win_q] : rise_q[win_q];
    den = dir_q ? rise_q[win_q] : fall_q[win_q];
  end
  logic [96:0] trial;
  assign trial = {rem_q, quo_q[79]} - {33'd0, den};

  logic [31:0] qsat;
  assign qsat = (quo_q[79:32] != '0) ? wudmr_pkg::QMax : quo_q[31:0];

  // A word moves into the output register when it is free or being taken.
  logic emit_fire;
  assign emit_fire = (state_q == wudmr_pkg::ST_EMIT) && (!ov_q || !out_stall_i);

  // Memory ports.
  always_comb begin
    mem_we    = (state_q == wudmr_pkg::ST_WRITE);
    mem_waddr = head_q;
    mem_raddr = slot_of(head_q, back_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= wudmr_pkg::ST_IDLE;
      head_q       <= '0;
      fill_q       <= '0;
      back_q       <= '0;
      ov_q         <= 1'b0;
    end else begin
      if (emit_fire) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (state_q)
        wudmr_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            quote_time_q  <= quote_time_i;
            quote_price_q <= quote_price_i;
            state_q       <= wudmr_pkg::ST_WRITE;
          end
        end
        wudmr_pkg::ST_WRITE: begin
          // Ring write; next read the oldest held entry.
          head_q  <= (head_q == AW'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
          fill_q  <= fill_new;
          back_q  <= fill_new - 1'b1;
          state_q <= wudmr_pkg::ST_FIRST;
        end
        wudmr_pkg::ST_FIRST: begin
          // Read issued for the oldest entry; the walk starts at the newest.
          back_q      <= '0;
          have_prev_q <= 1'b0;
          for (int w = 0; w < 4; w++) begin
            rise_q[w] <= '0;
            fall_q[w] <= '0;
          end
          state_q <= wudmr_pkg::ST_WALK;
        end
        wudmr_pkg::ST_WALK: begin
          if (!have_prev_q && back_q == '0) begin
            // Data holds the oldest entry time; the newest is being read.
            ready_q <= (quote_time_q - rd_time) > maxw;
            if ((quote_time_q - rd_time) > maxw && fill_q > FW'(1)) begin
              back_q <= FW'(1);
            end else begin
              win_q   <= '0;
              dir_q   <= 1'b0;
              step_q  <= '0;
              state_q <= wudmr_pkg::ST_DIV;
            end
          end else if (!have_prev_q) begin
            // Newest entry arrives; it is the newer side of the first pair.
            prev_price_q <= rd_price;
            ageq_q       <= age;
            have_prev_q  <= 1'b1;
            back_q       <= back_q + 1'b1;
          end else if (ageq_q > maxw) begin
            // The newer entry lies outside every window; the walk ends.
            win_q   <= '0;
            dir_q   <= 1'b0;
            step_q  <= '0;
            state_q <= wudmr_pkg::ST_DIV;
          end else begin
            // Data is the older entry of the pair, entry back_q - 1.
            for (int w = 0; w < 4; w++) begin
              if (3'(w) < cnt && !(ageq_q > len_q[w])) begin
                if (prev_price_q > rd_price)
                  rise_q[w] <= rise_q[w] + 64'(prev_price_q - rd_price);
                else if (prev_price_q < rd_price)
                  fall_q[w] <= fall_q[w] + 64'(rd_price - prev_price_q);
              end
            end
            prev_price_q <= rd_price;
            ageq_q       <= age;
            if (back_q >= fill_q) begin
              win_q   <= '0;
              dir_q   <= 1'b0;
              step_q  <= '0;
              state_q <= wudmr_pkg::ST_DIV;
            end else begin
              back_q <= back_q + 1'b1;
            end
          end
        end
        wudmr_pkg::ST_DIV: begin
          // Restoring division of num<<16 by den, one quotient bit per cycle.
          if (step_q == 7'd0) begin
            rem_q  <= '0;
            quo_q  <= {num, 16'd0};
            step_q <= 7'd1;
          end else if (step_q <= 7'd80) begin
            if (!trial[96]) begin
              rem_q <= trial[95:0];
              quo_q <= {quo_q[78:0], 1'b1};
            end else begin
              rem_q <= {rem_q[94:0], quo_q[79]};
              quo_q <= {quo_q[78:0], 1'b0};
            end
            step_q <= step_q + 1'b1;
          end else begin
            step_q <= '0;
            if (!dir_q) begin
              up_dz_q <= (den == '0);
              up_q    <= (den == '0) ? ((num != '0) ? wudmr_pkg::QMax : '0) : qsat;
              dir_q   <= 1'b1;
            end else begin
              dn_q    <= (den == '0) ? ((num != '0) ? wudmr_pkg::QMax : '0) : qsat;
              dn_dz_q <= (den == '0);
              state_q <= wudmr_pkg::ST_EMIT;
            end
          end
        end
        wudmr_pkg::ST_EMIT: begin
          if (emit_fire) begin
            o_win_q  <= win_q;
            o_up_q   <= ready_q ? up_q : '0;
            o_udz_q  <= ready_q & up_dz_q;
            o_dn_q   <= ready_q ? dn_q : '0;
            o_ddz_q  <= ready_q & dn_dz_q;
            o_rdy_q  <= ready_q;
            o_last_q <= (3'(win_q) + 3'd1 == cnt);
            if (3'(win_q) + 3'd1 == cnt) begin
              state_q <= wudmr_pkg::ST_HOLD;
            end else begin
              win_q   <= win_q + 1'b1;
              dir_q   <= 1'b0;
              state_q <= wudmr_pkg::ST_DIV;
            end
          end
        end
        wudmr_pkg::ST_HOLD: state_q <= wudmr_pkg::ST_IDLE;
        default: state_q <= wudmr_pkg::ST_IDLE;
      endcase
    end
  end

  // Checks.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != wudmr_pkg::ST_IDLE) |-> in_stall_o)
    else $error("input taken while busy");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthF)
    else $error("fill count above depth");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(o_up_q) && $stable(o_dn_q) &&
                               $stable(o_win_q)))
    else $error("stalled result changed");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
endmodule
`default_nettype wire
